// File: rtl/emgenv_pkg.sv
// Shared constants and widths for the EMG envelope trigger.
package emgenv_pkg;

    // Sample and fixed-point format.
    localparam int ADC_BITS  = 10;
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = ADC_BITS + FRAC_BITS;

    // Averaging rates are Q0.16.
    localparam int RATE_W    = 16;
    localparam int RATE_FRAC = 16;

    // Signed difference and product of the shared multiplier.
    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = DIFF_W + RATE_W + 1;

    // Field widths on the ports.
    localparam int SAMPLE_W = 10;
    localparam int TIME_W   = 32;
    localparam int THR_W    = 10;
    localparam int MS_W     = 16;
    localparam int ENV_W    = 26;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 32;

    // Configuration port.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_BASELINE_RATE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ENVELOPE_RATE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ON_THRESHOLD  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OFF_THRESHOLD = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MIN_ON_MS     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_REFRACTORY_MS = 3'd5;

    // Reset values of the registers.
    localparam logic [RATE_W-1:0] RST_BASELINE_RATE = 16'd328;
    localparam logic [RATE_W-1:0] RST_ENVELOPE_RATE = 16'd5243;
    localparam logic [THR_W-1:0]  RST_ON_THRESHOLD  = 10'd80;
    localparam logic [THR_W-1:0]  RST_OFF_THRESHOLD = 10'd60;
    localparam logic [MS_W-1:0]   RST_MIN_ON_MS     = 16'd80;
    localparam logic [MS_W-1:0]   RST_REFRACTORY_MS = 16'd120;

    // The baseline starts at mid-scale.
    localparam logic [VAL_W-1:0] BASELINE_INIT = VAL_W'(1) << (VAL_W - 1);

endpackage

// File: rtl/emg_envelope_trigger.sv
// EMG envelope detector with hysteresis, built around one shared multiplier.
//
//   Port group   Direction  Contents
//   s_axis_*     in         sample [9:0], now_ms [41:10]
//   m_axis_*     out        active [0], envelope_level [26:1]
//   APB          in/out     six configuration registers at 4*i
//
// Each sample passes through the accept step, then multiply and add for the
// baseline, rectification, multiply and add for the envelope, and the trigger
// decision. Both averages pass through the single multiplier in turn.
// Reset (aresetn low, synchronous) restores registers and detector state.
// A result waits in the output register; the next sample is taken meanwhile,
// and the decision step stalls only if the previous result is still waiting.
module emg_envelope_trigger
    import emgenv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input channel.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,   // sample [9:0], now_ms [41:10]
    // Result channel.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]   m_axis_tdata,   // active [0], envelope_level [26:1]
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_BMUL   = 3'd1;
    localparam logic [2:0] ST_BADD   = 3'd2;
    localparam logic [2:0] ST_RECT   = 3'd3;
    localparam logic [2:0] ST_EMUL   = 3'd4;
    localparam logic [2:0] ST_EADD   = 3'd5;
    localparam logic [2:0] ST_DECIDE = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [SAMPLE_W-1:0]    sample_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [VAL_W-1:0]       base_reg, env_reg, rect_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                   on_reg, on_next;
    logic [TIME_W-1:0]      last_reg, hold_reg;
    logic                   m_valid_reg;
    logic                   m_active_reg;
    logic [ENV_W-1:0]       m_env_reg;

    logic [RATE_W-1:0]      brate_reg, erate_reg, min_on_reg, refr_reg;
    logic [THR_W-1:0]       on_thr_reg, off_thr_reg;

    logic                   s_req, cfg_wr, out_free;
    logic [REG_IDX_W-1:0]   cfg_idx;
    logic [VAL_W-1:0]       sfx;
    logic [VAL_W-1:0]       mul_x, mul_avg, add_avg;
    logic [RATE_W-1:0]      mul_rate;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod_sh;
    logic [VAL_W-1:0]       blend;
    logic [VAL_W-1:0]       on_lvl, off_lvl;
    logic                   in_hold, in_refr, fire, release_on;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_req         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Configuration port: always ready, written in the access phase.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            REG_BASELINE_RATE: prdata = APB_DATA_W'(brate_reg);
            REG_ENVELOPE_RATE: prdata = APB_DATA_W'(erate_reg);
            REG_ON_THRESHOLD:  prdata = APB_DATA_W'(on_thr_reg);
            REG_OFF_THRESHOLD: prdata = APB_DATA_W'(off_thr_reg);
            REG_MIN_ON_MS:     prdata = APB_DATA_W'(min_on_reg);
            REG_REFRACTORY_MS: prdata = APB_DATA_W'(refr_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brate_reg   <= RST_BASELINE_RATE;
            erate_reg   <= RST_ENVELOPE_RATE;
            on_thr_reg  <= RST_ON_THRESHOLD;
            off_thr_reg <= RST_OFF_THRESHOLD;
            min_on_reg  <= RST_MIN_ON_MS;
            refr_reg    <= RST_REFRACTORY_MS;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BASELINE_RATE: brate_reg   <= pwdata[RATE_W-1:0];
                REG_ENVELOPE_RATE: erate_reg   <= pwdata[RATE_W-1:0];
                REG_ON_THRESHOLD:  on_thr_reg  <= pwdata[THR_W-1:0];
                REG_OFF_THRESHOLD: off_thr_reg <= pwdata[THR_W-1:0];
                REG_MIN_ON_MS:     min_on_reg  <= pwdata[MS_W-1:0];
                REG_REFRACTORY_MS: refr_reg    <= pwdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample aligned to the fixed-point format.
    assign sfx = VAL_W'({sample_reg[ADC_BITS-1:0], {FRAC_BITS{1'b0}}});

    // Shared multiplier: (x - avg) * rate, for the baseline or the envelope.
    assign mul_x    = (state_reg == ST_EMUL) ? rect_reg  : sfx;
    assign mul_avg  = (state_reg == ST_EMUL) ? env_reg   : base_reg;
    assign mul_rate = (state_reg == ST_EMUL) ? erate_reg : brate_reg;
    assign diff     = $signed({1'b0, mul_x}) - $signed({1'b0, mul_avg});
    assign prod_next = diff * $signed({1'b0, mul_rate});

    // Shared adder: avg + floor(product / 2^16). The true sum stays in range.
    assign add_avg = (state_reg == ST_EADD) ? env_reg : base_reg;
    assign prod_sh = prod_reg >>> RATE_FRAC;
    assign blend   = add_avg + prod_sh[VAL_W-1:0];

    // Trigger decision with hold time and refractory window.
    assign on_lvl     = VAL_W'({on_thr_reg, {FRAC_BITS{1'b0}}});
    assign off_lvl    = VAL_W'({off_thr_reg, {FRAC_BITS{1'b0}}});
    assign in_hold    = on_reg && (now_reg < hold_reg);
    assign in_refr    = (now_reg - last_reg) < TIME_W'(refr_reg);
    assign fire       = !in_hold && !on_reg && !in_refr && (env_reg >= on_lvl);
    assign release_on = !in_hold && on_reg && (env_reg <= off_lvl)
                        && (now_reg >= hold_reg);

    always_comb begin
        on_next = on_reg;
        if (fire) begin
            on_next = 1'b1;
        end else if (release_on) begin
            on_next = 1'b0;
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_req) state_next = ST_BMUL;
            ST_BMUL:   state_next = ST_BADD;
            ST_BADD:   state_next = ST_RECT;
            ST_RECT:   state_next = ST_EMUL;
            ST_EMUL:   state_next = ST_EADD;
            ST_EADD:   state_next = ST_DECIDE;
            ST_DECIDE: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control and detector state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            base_reg    <= BASELINE_INIT;
            env_reg     <= '0;
            on_reg      <= 1'b0;
            last_reg    <= '0;
            hold_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_BADD) begin
                base_reg <= blend;
            end
            if (state_reg == ST_EADD) begin
                env_reg <= blend;
            end
            // A decision loads the result; a waiting result leaves once taken.
            if (state_reg == ST_DECIDE && out_free) begin
                on_reg      <= on_next;
                m_valid_reg <= 1'b1;
                if (fire) begin
                    last_reg <= now_reg;
                    hold_reg <= now_reg + TIME_W'(min_on_reg);
                end
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge aclk) begin
        if (s_req) begin
            sample_reg <= s_axis_tdata[SAMPLE_W-1:0];
            now_reg    <= s_axis_tdata[SAMPLE_W +: TIME_W];
        end
        if (state_reg == ST_BMUL || state_reg == ST_EMUL) begin
            prod_reg <= prod_next;
        end
        // Rectified difference from the updated baseline.
        if (state_reg == ST_RECT) begin
            rect_reg <= (sfx >= base_reg) ? (sfx - base_reg) : (base_reg - sfx);
        end
        if (state_reg == ST_DECIDE && out_free) begin
            m_active_reg <= on_next;
            m_env_reg    <= ENV_W'(env_reg);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_DATA_W'({m_env_reg, m_active_reg});

endmodule
